// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl of the bracket balance checker
// depends on nothing; every macro is empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define BBC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("bbc assertion failed");
// implication checked in the same cycle
`define BBC_ASSERT_IMPL(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("bbc implication failed");
`else
`define BBC_ASSERT(label, clk, rst, prop)
`define BBC_ASSERT_IMPL(label, clk, rst, cond, prop)
`endif
`endif

// ===== rtl/core/bbc_pkg.sv =====
// types, character codes and the byte classifier of the bracket balance checker
// depends on nothing
`default_nettype none

package bbc_pkg;

  // report codes carried in the result
  typedef enum logic [2:0] {
    RK_OK           = 3'd0,
    RK_NEVER_OPENED = 3'd1,
    RK_WRONG_CLOSE  = 3'd2,
    RK_NEVER_CLOSED = 3'd3,
    RK_OVERFLOW     = 3'd4
  } report_kind_t;

  // control states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_DRAIN
  } bbc_state_t;

  // bracket kinds
  localparam logic [1:0] KIND_PAREN  = 2'd0;
  localparam logic [1:0] KIND_SQUARE = 2'd1;
  localparam logic [1:0] KIND_CURLY  = 2'd2;
  localparam logic [1:0] KIND_ANGLE  = 2'd3;

  // character codes
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LCURLY  = 8'h7B;
  localparam logic [7:0] CH_RCURLY  = 8'h7D;
  localparam logic [7:0] CH_LANGLE  = 8'h3C;
  localparam logic [7:0] CH_RANGLE  = 8'h3E;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam int unsigned REPORT_LINE_BITS = 16;
  localparam int unsigned RESULT_BITS      = 40;

  typedef struct packed {
    logic       is_open;
    logic       is_close;
    logic [1:0] kind;
  } char_class_t;

  function automatic char_class_t classify(input logic [7:0] ch);
    char_class_t c;
    c = '0;
    case (ch)
      CH_LPAREN:  begin c.is_open  = 1'b1; c.kind = KIND_PAREN;  end
      CH_LSQUARE: begin c.is_open  = 1'b1; c.kind = KIND_SQUARE; end
      CH_LCURLY:  begin c.is_open  = 1'b1; c.kind = KIND_CURLY;  end
      CH_LANGLE:  begin c.is_open  = 1'b1; c.kind = KIND_ANGLE;  end
      CH_RPAREN:  begin c.is_close = 1'b1; c.kind = KIND_PAREN;  end
      CH_RSQUARE: begin c.is_close = 1'b1; c.kind = KIND_SQUARE; end
      CH_RCURLY:  begin c.is_close = 1'b1; c.kind = KIND_CURLY;  end
      CH_RANGLE:  begin c.is_close = 1'b1; c.kind = KIND_ANGLE;  end
      default:    c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bracket_balance_checker_unit.sv =====
// top level of the bracket balance checker: stack memory, line counter, control
// depends on bbc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// Bracket balance checker. Text bytes enter on the s_ side, one per transaction; s_tlast
// high marks end of text. Openers of the four kinds (), [], {}, <> are pushed with their
// line number onto a stack held in one synchronous memory of STACK_DEPTH entries; lines
// count from one and advance on each newline. Reports leave on the m_ side through one
// output register, m_tlast marking the last report caused by an input transaction.
// Steps: a newline, an opener or any other byte is handled in ST_IDLE; a closer on a non-empty
// stack also passes through ST_CLOSE, since the top entry must be read from the stack memory
// before it can be compared; end of text with brackets still open walks them in ST_DRAIN from
// the bottom through the memory read port, one entry per cycle while the sink takes reports.
// s_tready is low outside ST_IDLE and while a report sits in the output register untaken.
module bracket_balance_checker_unit
  import bbc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned LINE_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
  input  wire logic        s_tlast,   // end_of_text
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [2:0] report_kind, [4:3] open_kind, [20:5] open_line, [22:21] close_kind,
  // [38:23] close_line, [39] zero fill
  output logic [RESULT_BITS-1:0] m_tdata,
  output logic             m_tlast    // last_report
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned EW = 2 + LINE_BITS;

  // stack memory, kind in the low bits, line above
  logic [EW-1:0] stack_mem [STACK_DEPTH];
  logic [EW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  // control registers
  bbc_state_t     state, state_next;
  logic [CW-1:0]  stack_count, stack_count_next;
  logic [LINE_BITS-1:0] current_line, current_line_next;
  logic           error_seen, error_seen_next;
  logic [AW-1:0]  ptr, ptr_next;
  logic [1:0]     close_kind, close_kind_next;

  // output register
  logic           out_load;
  report_kind_t   out_kind, out_kind_next;
  logic [1:0]     out_okind, out_okind_next;
  logic [REPORT_LINE_BITS-1:0] out_oline, out_oline_next;
  logic [1:0]     out_ckind, out_ckind_next;
  logic [REPORT_LINE_BITS-1:0] out_cline, out_cline_next;
  logic           out_last, out_last_next;

  logic           out_free;
  logic           in_accept;
  char_class_t    cls;
  logic [CW-1:0]  count_m1;
  logic [AW-1:0]  top_addr;
  logic [1:0]     rd_kind;
  logic [LINE_BITS-1:0] rd_line;
  logic [REPORT_LINE_BITS-1:0] line_rep;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && out_free;
  assign in_accept = s_tvalid && s_tready;
  assign cls       = classify(s_tdata);
  assign count_m1  = stack_count - CW'(1);
  assign top_addr  = count_m1[AW-1:0];
  assign rd_kind   = rd_data[1:0];
  assign rd_line   = rd_data[EW-1:2];
  assign line_rep  = REPORT_LINE_BITS'(current_line);

  // stack memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    rd_data <= stack_mem[rd_addr];
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      stack_count  <= '0;
      current_line <= LINE_BITS'(1);
      error_seen   <= 1'b0;
      ptr          <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state        <= state_next;
      stack_count  <= stack_count_next;
      current_line <= current_line_next;
      error_seen   <= error_seen_next;
      ptr          <= ptr_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    close_kind <= close_kind_next;
    if (out_load) begin
      out_kind  <= out_kind_next;
      out_okind <= out_okind_next;
      out_oline <= out_oline_next;
      out_ckind <= out_ckind_next;
      out_cline <= out_cline_next;
      out_last  <= out_last_next;
    end
  end

  // next state, stack access and report generation
  always_comb begin
    state_next        = state;
    stack_count_next  = stack_count;
    current_line_next = current_line;
    error_seen_next   = error_seen;
    ptr_next          = ptr;
    close_kind_next   = close_kind;
    rd_addr           = top_addr;
    wr_en             = 1'b0;
    wr_addr           = stack_count[AW-1:0];
    wr_data           = {current_line, cls.kind};
    out_load          = 1'b0;
    out_kind_next     = RK_OK;
    out_okind_next    = '0;
    out_oline_next    = '0;
    out_ckind_next    = '0;
    out_cline_next    = '0;
    out_last_next     = 1'b1;

    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (s_tlast) begin
            // end of text: walk the open entries or report ok
            if (stack_count != '0) begin
              ptr_next   = '0;
              rd_addr    = '0;
              state_next = ST_DRAIN;
            end else begin
              out_load          = !error_seen;
              current_line_next = LINE_BITS'(1);
              error_seen_next   = 1'b0;
            end
          end else if (s_tdata == CH_NEWLINE) begin
            current_line_next = current_line + LINE_BITS'(1);
          end else if (cls.is_open) begin
            if (stack_count < CW'(STACK_DEPTH)) begin
              wr_en            = 1'b1;
              stack_count_next = stack_count + CW'(1);
            end else begin
              error_seen_next = 1'b1;
              out_load        = 1'b1;
              out_kind_next   = RK_OVERFLOW;
              out_okind_next  = cls.kind;
              out_oline_next  = line_rep;
            end
          end else if (cls.is_close) begin
            if (stack_count == '0) begin
              error_seen_next = 1'b1;
              out_load        = 1'b1;
              out_kind_next   = RK_NEVER_OPENED;
              out_ckind_next  = cls.kind;
              out_cline_next  = line_rep;
            end else begin
              // top entry arrives from memory next cycle
              close_kind_next = cls.kind;
              state_next      = ST_CLOSE;
            end
          end
        end
      end

      ST_CLOSE: begin
        // compare against the top and pop it
        if (rd_kind != close_kind) begin
          error_seen_next = 1'b1;
          out_load        = 1'b1;
          out_kind_next   = RK_WRONG_CLOSE;
          out_okind_next  = rd_kind;
          out_oline_next  = REPORT_LINE_BITS'(rd_line);
          out_ckind_next  = close_kind;
          out_cline_next  = line_rep;
        end
        stack_count_next = count_m1;
        state_next       = ST_IDLE;
      end

      ST_DRAIN: begin
        // one open entry per cycle from the bottom up, while the output register is free
        rd_addr = ptr;
        if (out_free) begin
          out_load       = 1'b1;
          out_kind_next  = RK_NEVER_CLOSED;
          out_okind_next = rd_kind;
          out_oline_next = REPORT_LINE_BITS'(rd_line);
          out_last_next  = (CW'(ptr) + CW'(1)) == stack_count;
          if (out_last_next) begin
            stack_count_next  = '0;
            current_line_next = LINE_BITS'(1);
            error_seen_next   = 1'b0;
            ptr_next          = '0;
            state_next        = ST_IDLE;
          end else begin
            ptr_next = ptr + AW'(1);
            rd_addr  = ptr_next;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign m_tdata = {1'b0, out_cline, out_ckind, out_oline, out_okind, out_kind};
  assign m_tlast = out_last;

  // checks
  `BBC_ASSERT(a_count_bound, clk, rst, stack_count <= CW'(STACK_DEPTH))
  `BBC_ASSERT(a_no_overwrite, clk, rst, !(out_load && m_tvalid && !m_tready))
  `BBC_ASSERT_IMPL(a_close_nonempty, clk, rst, state == ST_CLOSE, stack_count != '0)
  `BBC_ASSERT_IMPL(a_drain_ptr, clk, rst, state == ST_DRAIN, CW'(ptr) < stack_count)

endmodule

`default_nettype wire

// ===== dv/bbc_checker.sv =====
// checker for the bracket balance checker: watches both stream channels, predicts the
// reports from the accepted text and compares them field by field; depends on bbc_pkg
`default_nettype none

module bbc_checker
  import bbc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  input  wire logic                   s_tready,
  input  wire logic [7:0]             s_tdata,
  input  wire logic                   s_tlast,
  input  wire logic                   m_tvalid,
  input  wire logic                   m_tready,
  input  wire logic [RESULT_BITS-1:0] m_tdata,
  input  wire logic                   m_tlast,
  output int unsigned                 fail_count,
  output int unsigned                 reports_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_SHOWN = 10;

  typedef struct packed {
    report_kind_t kind;
    logic [1:0]   open_kind;
    logic [15:0]  open_line;
    logic [1:0]   close_kind;
    logic [15:0]  close_line;
    logic         last;
  } bracket_report_t;

  // predicted bracket stack and text position
  logic [1:0]  open_kinds [STACK_DEPTH];
  logic [15:0] open_lines [STACK_DEPTH];
  int unsigned open_count;
  logic [15:0] line_no;
  logic        had_error;

  bracket_report_t expected_reports [$];

  task automatic push_report(input report_kind_t kind, input logic [1:0] ok,
                             input logic [15:0] ol, input logic [1:0] ck,
                             input logic [15:0] cl, input logic last);
    bracket_report_t r;
    r.kind       = kind;
    r.open_kind  = ok;
    r.open_line  = ol;
    r.close_kind = ck;
    r.close_line = cl;
    r.last       = last;
    expected_reports.push_back(r);
  endtask

  // work out the reports caused by one text transaction
  task automatic predict_text(input logic [7:0] ch, input logic eot);
    logic        is_open;
    logic        is_close;
    logic [1:0]  k;
    int unsigned i;
    is_open  = 1'b0;
    is_close = 1'b0;
    k        = KIND_PAREN;
    if (eot) begin
      // bottom-up list of brackets left open, or ok on a clean stream
      for (i = 0; i < open_count; i++) begin
        push_report(RK_NEVER_CLOSED, open_kinds[i], open_lines[i], 2'd0, 16'd0,
                    i + 1 == open_count);
      end
      if (open_count == 0 && !had_error) begin
        push_report(RK_OK, 2'd0, 16'd0, 2'd0, 16'd0, 1'b1);
      end
      open_count = 0;
      line_no    = 16'd1;
      had_error  = 1'b0;
    end else if (ch == CH_NEWLINE) begin
      line_no = line_no + 16'd1;
    end else begin
      case (ch)
        CH_LPAREN:  begin is_open  = 1'b1; k = KIND_PAREN;  end
        CH_LSQUARE: begin is_open  = 1'b1; k = KIND_SQUARE; end
        CH_LCURLY:  begin is_open  = 1'b1; k = KIND_CURLY;  end
        CH_LANGLE:  begin is_open  = 1'b1; k = KIND_ANGLE;  end
        CH_RPAREN:  begin is_close = 1'b1; k = KIND_PAREN;  end
        CH_RSQUARE: begin is_close = 1'b1; k = KIND_SQUARE; end
        CH_RCURLY:  begin is_close = 1'b1; k = KIND_CURLY;  end
        CH_RANGLE:  begin is_close = 1'b1; k = KIND_ANGLE;  end
        default: ;
      endcase
      if (is_open) begin
        // a full stack drops the opener and reports it
        if (open_count < STACK_DEPTH) begin
          open_kinds[open_count] = k;
          open_lines[open_count] = line_no;
          open_count++;
        end else begin
          had_error = 1'b1;
          push_report(RK_OVERFLOW, k, line_no, 2'd0, 16'd0, 1'b1);
        end
      end else if (is_close) begin
        if (open_count == 0) begin
          had_error = 1'b1;
          push_report(RK_NEVER_OPENED, 2'd0, 16'd0, k, line_no, 1'b1);
        end else begin
          // the top is popped whether or not the kinds agree
          if (open_kinds[open_count-1] != k) begin
            had_error = 1'b1;
            push_report(RK_WRONG_CLOSE, open_kinds[open_count-1],
                        open_lines[open_count-1], k, line_no, 1'b1);
          end
          open_count--;
        end
      end
    end
  endtask

  // compare one report against the oldest prediction
  task automatic check_report();
    bracket_report_t want;
    if (expected_reports.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_SHOWN) begin
        $display("unexpected report: tdata=%h tlast=%b", m_tdata, m_tlast);
      end
    end else begin
      want = expected_reports.pop_front();
      if (m_tdata[2:0] !== want.kind || m_tdata[4:3] !== want.open_kind ||
          m_tdata[20:5] !== want.open_line || m_tdata[22:21] !== want.close_kind ||
          m_tdata[38:23] !== want.close_line || m_tdata[RESULT_BITS-1] !== 1'b0 ||
          m_tlast !== want.last) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN) begin
          $display("report mismatch: expected kind=%0d ok=%0d ol=%0d ck=%0d cl=%0d last=%0b",
                   want.kind, want.open_kind, want.open_line, want.close_kind,
                   want.close_line, want.last);
          $display("                 actual   kind=%0d ok=%0d ol=%0d ck=%0d cl=%0d last=%0b fill=%0b",
                   m_tdata[2:0], m_tdata[4:3], m_tdata[20:5], m_tdata[22:21],
                   m_tdata[38:23], m_tlast, m_tdata[RESULT_BITS-1]);
        end
      end
    end
  endtask

  // reports leave a register, so one taken at this edge stems from earlier text
  always @(posedge clk) begin
    if (rst) begin
      open_count = 0;
      line_no    = 16'd1;
      had_error  = 1'b0;
      expected_reports.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        check_report();
      end
      if (s_tvalid && s_tready) begin
        predict_text(s_tdata, s_tlast);
      end
    end
    reports_pending = expected_reports.size();
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// top of the bracket balance checker testbench: clock, reset, text stimulus and verdict
// depends on bbc_pkg, bbc_checker and bracket_balance_checker_unit
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bbc_pkg::*;

  localparam int unsigned STACK_DEPTH  = 32;
  localparam int unsigned LINE_BITS    = 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS  = 85;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata  = 8'h00;
  logic                   s_tlast  = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [RESULT_BITS-1:0] m_tdata;
  logic                   m_tlast;

  int unsigned fail_count;
  int unsigned reports_pending;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned items_sent    = 0;
  int unsigned cycle_count   = 0;

  bracket_balance_checker_unit #(
    .STACK_DEPTH (STACK_DEPTH),
    .LINE_BITS   (LINE_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  bbc_checker #(
    .STACK_DEPTH (STACK_DEPTH)
  ) checker_i (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast),
    .fail_count      (fail_count),
    .reports_pending (reports_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // report sink with random back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [1:0] rand_kind();
    int unsigned r;
    r = $urandom_range(3);
    return r[1:0];
  endfunction

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(255);
    return r[7:0];
  endfunction

  function automatic logic [7:0] open_char(input logic [1:0] k);
    case (k)
      KIND_PAREN:  return CH_LPAREN;
      KIND_SQUARE: return CH_LSQUARE;
      KIND_CURLY:  return CH_LCURLY;
      default:     return CH_LANGLE;
    endcase
  endfunction

  function automatic logic [7:0] close_char(input logic [1:0] k);
    case (k)
      KIND_PAREN:  return CH_RPAREN;
      KIND_SQUARE: return CH_RSQUARE;
      KIND_CURLY:  return CH_RCURLY;
      default:     return CH_RANGLE;
    endcase
  endfunction

  // one text transaction, entered and left at a falling edge
  task automatic put_item(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic eot_after);
    int i;
    for (i = 0; i < s.len(); i++) begin
      put_item(s[i], 1'b0);
    end
    if (eot_after) begin
      put_item(rand_byte(), 1'b1);
    end
  endtask

  // hold the sender off until every predicted report has come out
  task automatic wait_reports_out();
    s_tvalid <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
  endtask

  // mostly well-nested text with random filler, some broken closers, then end of text
  task automatic send_stream(input int unsigned max_len, input int unsigned err_pct,
                             input int unsigned pre_open);
    logic [1:0]  nest [$];
    logic [1:0]  k;
    int unsigned len;
    int unsigned n;
    int unsigned pick;
    int unsigned skew;
    for (n = 0; n < pre_open; n++) begin
      k = rand_kind();
      nest.push_back(k);
      put_item(open_char(k), 1'b0);
    end
    len = $urandom_range(max_len, 1);
    for (n = 0; n < len; n++) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        k = rand_kind();
        nest.push_back(k);
        put_item(open_char(k), 1'b0);
      end else if (pick < 60 && nest.size() != 0) begin
        k = nest.pop_back();
        if ($urandom_range(99) < err_pct) begin
          skew = $urandom_range(3, 1);
          k = k + skew[1:0];
        end
        put_item(close_char(k), 1'b0);
      end else if (pick < 60 && $urandom_range(99) < err_pct) begin
        put_item(close_char(rand_kind()), 1'b0);
      end else if ($urandom_range(99) < 15) begin
        put_item(CH_NEWLINE, 1'b0);
      end else begin
        put_item(rand_byte(), 1'b0);
      end
    end
    if ($urandom_range(99) >= err_pct) begin
      while (nest.size() != 0) put_item(close_char(nest.pop_back()), 1'b0);
    end
    put_item(rand_byte(), 1'b1);
  endtask

  task automatic random_phase(input int unsigned idle_pct, input int unsigned stall);
    int unsigned start;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    start         = items_sent;
    // one stream opening 30 to 36 brackets first, near or past the stack depth
    send_stream(6, 10, $urandom_range(36, 30));
    while (items_sent - start < PHASE_ITEMS) begin
      send_stream(20, 12, 0);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed text: clean, wrong kind, never opened, left open, odd bytes
    put_item(8'h00, 1'b1);
    send_text("()", 1'b1);
    send_text("{\n>", 1'b1);
    send_text("]", 1'b1);
    put_item(8'h00, 1'b0);
    put_item(8'hFF, 1'b0);
    send_text("<\n[{}", 1'b1);

    random_phase(0, 0);
    wait_reports_out();
    random_phase(45, 0);
    random_phase(0, 45);
    random_phase(29, 29);

    // let the last reports out and watch for stray ones
    s_tvalid  <= 1'b0;
    stall_pct = 0;
    while (reports_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && reports_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/bbc_pkg.sv
rtl/core/bracket_balance_checker_unit.sv
dv/bbc_checker.sv
dv/tb_top.sv
